/* hw/rtl/mrg_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths and per-mode constants for the raw-to-gauss converter
package mrg_pkg;

  localparam int RAW_W    = 16;
  localparam int MODE_W   = 2;
  localparam int AXIS_W   = 2;
  localparam int MAG_W    = 16;
  localparam int SENS_W   = 11;
  localparam int RECIP_W  = 27;
  localparam int RECIP_SH = 32;
  localparam int QUOT_W   = 11;
  localparam int REM_W    = 10;
  localparam int NUM_W    = 30;
  localparam int FRAC_U_W = 20;
  localparam int TWHOLE_W = 12;
  localparam int TFRAC_W  = 21;
  localparam int WHOLE_W  = 13;
  localparam int FRAC_W   = 22;

  localparam int TERM_STAGES = 8;
  localparam int STAGES      = TERM_STAGES + 1;

  localparam logic [FRAC_U_W-1:0] MICRO_SCALE = FRAC_U_W'(1000000);

  localparam logic [MAG_W-1:0] OFFSET_16 = MAG_W'(32768);
  localparam logic [MAG_W-1:0] OFFSET_14 = MAG_W'(8192);
  localparam logic [MAG_W-1:0] OFFSET_12 = MAG_W'(2048);

  localparam logic [SENS_W-1:0] SENS_XY_16 = SENS_W'(1024);
  localparam logic [SENS_W-1:0] SENS_XY_14 = SENS_W'(256);
  localparam logic [SENS_W-1:0] SENS_XY_12 = SENS_W'(64);
  localparam logic [SENS_W-1:0] SENS_Z_16  = SENS_W'(770);
  localparam logic [SENS_W-1:0] SENS_Z_14  = SENS_W'(193);
  localparam logic [SENS_W-1:0] SENS_Z_12  = SENS_W'(48);

  // floor(2^32 / sens), the estimate is then at most one below the true quotient
  localparam logic [RECIP_W-1:0] RECIP_XY_16 = RECIP_W'((64'd1 << RECIP_SH) / 1024);
  localparam logic [RECIP_W-1:0] RECIP_XY_14 = RECIP_W'((64'd1 << RECIP_SH) / 256);
  localparam logic [RECIP_W-1:0] RECIP_XY_12 = RECIP_W'((64'd1 << RECIP_SH) / 64);
  localparam logic [RECIP_W-1:0] RECIP_Z_16  = RECIP_W'((64'd1 << RECIP_SH) / 770);
  localparam logic [RECIP_W-1:0] RECIP_Z_14  = RECIP_W'((64'd1 << RECIP_SH) / 193);
  localparam logic [RECIP_W-1:0] RECIP_Z_12  = RECIP_W'((64'd1 << RECIP_SH) / 48);

  typedef enum logic [MODE_W-1:0] {
    MODE_16     = 2'd0,
    MODE_16_ALT = 2'd1,
    MODE_14     = 2'd2,
    MODE_12     = 2'd3
  } mode_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  function automatic logic [MAG_W-1:0] mode_offset(input mode_t mode);
    case (mode)
      MODE_14: mode_offset = OFFSET_14;
      MODE_12: mode_offset = OFFSET_12;
      default: mode_offset = OFFSET_16;
    endcase
  endfunction

  function automatic logic [SENS_W-1:0] mode_sens_xy(input mode_t mode);
    case (mode)
      MODE_14: mode_sens_xy = SENS_XY_14;
      MODE_12: mode_sens_xy = SENS_XY_12;
      default: mode_sens_xy = SENS_XY_16;
    endcase
  endfunction

  function automatic logic [SENS_W-1:0] mode_sens_z(input mode_t mode);
    case (mode)
      MODE_14: mode_sens_z = SENS_Z_14;
      MODE_12: mode_sens_z = SENS_Z_12;
      default: mode_sens_z = SENS_Z_16;
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] mode_recip_xy(input mode_t mode);
    case (mode)
      MODE_14: mode_recip_xy = RECIP_XY_14;
      MODE_12: mode_recip_xy = RECIP_XY_12;
      default: mode_recip_xy = RECIP_XY_16;
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] mode_recip_z(input mode_t mode);
    case (mode)
      MODE_14: mode_recip_z = RECIP_Z_14;
      MODE_12: mode_recip_z = RECIP_Z_12;
      default: mode_recip_z = RECIP_Z_16;
    endcase
  endfunction

endpackage

/* hw/rtl/magnetometer_raw_to_gauss.sv */
`timescale 1ns / 1ps
// Raw magnetometer samples to gauss for one selected axis. One sample set is
// taken every clock cycle unless the output stalls and in_ready drops. Each axis
// runs through an eight-stage divide pipeline (reciprocal multiply, back-multiply
// and correct, once for the quotient and once for the micro fraction) and a
// final register combines the terms for X, Y or Z. A stalled output holds the
// pipeline only as far back as it is full, so bubbles are squeezed out before
// in_ready drops. cfg_data selects the resolution mode and is taken at once;
// write it only while no transfer is in flight.
module magnetometer_raw_to_gauss (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mrg_pkg::MODE_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mrg_pkg::RAW_W-1:0]              raw_x,
  input  logic [mrg_pkg::RAW_W-1:0]              raw_y,
  input  logic [mrg_pkg::RAW_W-1:0]              raw_z,
  input  logic [mrg_pkg::AXIS_W-1:0]             axis,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mrg_pkg::WHOLE_W-1:0]     whole_gauss,
  output logic signed [mrg_pkg::FRAC_W-1:0]      micro_fraction,
  output logic                                   bad_axis
);
  import mrg_pkg::*;

  mode_t mode;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] en;
  axis_t             axis_pipe [TERM_STAGES];

  logic [MAG_W-1:0]    offset;
  logic [SENS_W-1:0]   sens_xy;
  logic [SENS_W-1:0]   sens_z;
  logic [RECIP_W-1:0]  recip_xy;
  logic [RECIP_W-1:0]  recip_z;

  logic signed [TWHOLE_W-1:0] wx, wy, wz;
  logic signed [TFRAC_W-1:0]  fx, fy, fz;
  logic signed [WHOLE_W-1:0]  wx_e, wy_e, wz_e;
  logic signed [FRAC_W-1:0]   fx_e, fy_e, fz_e;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_16;
    end else if (cfg_valid && cfg_ready) begin
      mode <= mode_t'(cfg_data);
    end
  end

  assign offset   = mode_offset(mode);
  assign sens_xy  = mode_sens_xy(mode);
  assign sens_z   = mode_sens_z(mode);
  assign recip_xy = mode_recip_xy(mode);
  assign recip_z  = mode_recip_z(mode);

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      axis_pipe[0] <= axis_t'(axis);
    end
    for (int i = 1; i < TERM_STAGES; i++) begin
      if (en[i]) begin
        axis_pipe[i] <= axis_pipe[i-1];
      end
    end
  end

  mrg_term u_term_x (
    .clk    (clk),
    .en     (en[TERM_STAGES-1:0]),
    .raw    (raw_x),
    .offset (offset),
    .sens   (sens_xy),
    .recip  (recip_xy),
    .whole  (wx),
    .frac   (fx)
  );

  mrg_term u_term_y (
    .clk    (clk),
    .en     (en[TERM_STAGES-1:0]),
    .raw    (raw_y),
    .offset (offset),
    .sens   (sens_xy),
    .recip  (recip_xy),
    .whole  (wy),
    .frac   (fy)
  );

  mrg_term u_term_z (
    .clk    (clk),
    .en     (en[TERM_STAGES-1:0]),
    .raw    (raw_z),
    .offset (offset),
    .sens   (sens_z),
    .recip  (recip_z),
    .whole  (wz),
    .frac   (fz)
  );

  assign wx_e = {wx[TWHOLE_W-1], wx};
  assign wy_e = {wy[TWHOLE_W-1], wy};
  assign wz_e = {wz[TWHOLE_W-1], wz};
  assign fx_e = {fx[TFRAC_W-1], fx};
  assign fy_e = {fy[TFRAC_W-1], fy};
  assign fz_e = {fz[TFRAC_W-1], fz};

  // whole parts and fractions combine separately, no carry between them
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      case (axis_pipe[TERM_STAGES-1])
        AXIS_X: begin
          whole_gauss    <= wx_e;
          micro_fraction <= fx_e;
          bad_axis       <= 1'b0;
        end
        AXIS_Y: begin
          whole_gauss    <= wy_e - wz_e;
          micro_fraction <= fy_e - fz_e;
          bad_axis       <= 1'b0;
        end
        AXIS_Z: begin
          whole_gauss    <= wy_e + wz_e;
          micro_fraction <= fy_e + fz_e;
          bad_axis       <= 1'b0;
        end
        default: begin
          whole_gauss    <= '0;
          micro_fraction <= '0;
          bad_axis       <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mrg_term.sv */
`timescale 1ns / 1ps
// eight-stage pipeline turning one raw axis sample into a signed whole part and micro fraction
module mrg_term (
  input  logic                                   clk,
  input  logic [mrg_pkg::TERM_STAGES-1:0]        en,
  input  logic [mrg_pkg::RAW_W-1:0]              raw,
  input  logic [mrg_pkg::MAG_W-1:0]              offset,
  input  logic [mrg_pkg::SENS_W-1:0]             sens,
  input  logic [mrg_pkg::RECIP_W-1:0]            recip,
  output logic signed [mrg_pkg::TWHOLE_W-1:0]    whole,
  output logic signed [mrg_pkg::TFRAC_W-1:0]     frac
);
  import mrg_pkg::*;

  localparam int DIFF_W = RAW_W + 2;
  localparam int P1_W   = MAG_W + RECIP_W;
  localparam int P2_W   = NUM_W + RECIP_W;

  // stage 1: centre and split into sign and magnitude
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] diff_abs;
  logic [MAG_W-1:0]  mag1;
  logic              neg1;

  // stage 2: quotient estimate
  logic [P1_W-1:0]   prod_q;
  logic [QUOT_W-1:0] qe2;
  logic [MAG_W-1:0]  mag2;
  logic              neg2;

  // stage 3: back-multiply
  logic [MAG_W-1:0]  qs3;
  logic [QUOT_W-1:0] qe3;
  logic [MAG_W-1:0]  mag3;
  logic              neg3;

  // stage 4: correct quotient and remainder
  logic [MAG_W-1:0]  r0;
  logic [MAG_W-1:0]  r0_adj;
  logic [QUOT_W-1:0] q4;
  logic [REM_W-1:0]  r4;
  logic              neg4;

  // stage 5: scale remainder to millionths
  logic [NUM_W-1:0]  n5;
  logic [QUOT_W-1:0] q5;
  logic              neg5;

  // stage 6: fraction estimate
  logic [P2_W-1:0]     prod_f;
  logic [FRAC_U_W-1:0] fe6;
  logic [NUM_W-1:0]    n6;
  logic [QUOT_W-1:0]   q6;
  logic                neg6;

  // stage 7: back-multiply fraction
  logic [NUM_W-1:0]    fs7;
  logic [FRAC_U_W-1:0] fe7;
  logic [NUM_W-1:0]    n7;
  logic [QUOT_W-1:0]   q7;
  logic                neg7;

  // stage 8: correct fraction and restore sign
  logic [NUM_W-1:0]    r2;
  logic [FRAC_U_W-1:0] f8;

  assign diff     = {2'b00, raw} - {2'b00, offset};
  assign diff_abs = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag1 <= diff_abs[MAG_W-1:0];
      neg1 <= diff[DIFF_W-1];
    end
  end

  assign prod_q = P1_W'(mag1) * P1_W'(recip);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qe2  <= prod_q[RECIP_SH +: QUOT_W];
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      qs3  <= MAG_W'(qe2 * sens);
      qe3  <= qe2;
      mag3 <= mag2;
      neg3 <= neg2;
    end
  end

  assign r0     = mag3 - qs3;
  assign r0_adj = r0 - MAG_W'(sens);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (r0 >= MAG_W'(sens)) begin
        q4 <= qe3 + QUOT_W'(1);
        r4 <= r0_adj[REM_W-1:0];
      end else begin
        q4 <= qe3;
        r4 <= r0[REM_W-1:0];
      end
      neg4 <= neg3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      n5   <= NUM_W'(r4) * NUM_W'(MICRO_SCALE);
      q5   <= q4;
      neg5 <= neg4;
    end
  end

  assign prod_f = P2_W'(n5) * P2_W'(recip);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      fe6  <= prod_f[RECIP_SH +: FRAC_U_W];
      n6   <= n5;
      q6   <= q5;
      neg6 <= neg5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      fs7  <= NUM_W'(fe6) * NUM_W'(sens);
      fe7  <= fe6;
      n7   <= n6;
      q7   <= q6;
      neg7 <= neg6;
    end
  end

  assign r2 = n7 - fs7;
  assign f8 = (r2 >= NUM_W'(sens)) ? fe7 + FRAC_U_W'(1) : fe7;

  // truncation toward zero is symmetric, so the sign goes back on at the end
  always_ff @(posedge clk) begin
    if (en[7]) begin
      if (neg7) begin
        whole <= TWHOLE_W'(0) - TWHOLE_W'(q7);
        frac  <= TFRAC_W'(0) - TFRAC_W'(f8);
      end else begin
        whole <= TWHOLE_W'(q7);
        frac  <= TFRAC_W'(f8);
      end
    end
  end

endmodule
